/* design/sts_pkg.sv */
// Shared types, constants and lookup functions for the script token scanner.
`default_nettype none
package sts_pkg;

	localparam int POS_BITS_DEF      = 24;
	localparam int KEYWORD_CHARS_DEF = 5;
	localparam int FIELD_W           = 24;
	localparam int KIND_W            = 5;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_NAME    = 2'd1,
		MODE_NUMBER  = 2'd2,
		MODE_COMMENT = 2'd3
	} mode_t;

	localparam logic [KIND_W-1:0] KIND_END    = 5'd0;
	localparam logic [KIND_W-1:0] KIND_NAME   = 5'd1;
	localparam logic [KIND_W-1:0] KIND_NUMBER = 5'd2;
	localparam logic [KIND_W-1:0] KIND_INT    = 5'd3;
	localparam logic [KIND_W-1:0] KIND_CHAR   = 5'd4;
	localparam logic [KIND_W-1:0] KIND_FUNC   = 5'd5;
	localparam logic [KIND_W-1:0] KIND_IF     = 5'd6;
	localparam logic [KIND_W-1:0] KIND_WHILE  = 5'd7;
	localparam logic [KIND_W-1:0] KIND_LPAREN = 5'd8;
	localparam logic [KIND_W-1:0] KIND_RPAREN = 5'd9;
	localparam logic [KIND_W-1:0] KIND_LBRACE = 5'd10;
	localparam logic [KIND_W-1:0] KIND_RBRACE = 5'd11;
	localparam logic [KIND_W-1:0] KIND_PLUS   = 5'd12;
	localparam logic [KIND_W-1:0] KIND_MINUS  = 5'd13;
	localparam logic [KIND_W-1:0] KIND_STAR   = 5'd14;
	localparam logic [KIND_W-1:0] KIND_SLASH  = 5'd15;
	localparam logic [KIND_W-1:0] KIND_EQUAL  = 5'd16;
	localparam logic [KIND_W-1:0] KIND_GT     = 5'd17;
	localparam logic [KIND_W-1:0] KIND_LT     = 5'd18;
	localparam logic [KIND_W-1:0] KIND_COMMA  = 5'd19;
	localparam logic [KIND_W-1:0] KIND_CARET  = 5'd20;

	// keyword spellings, first character in the high byte
	localparam logic [23:0] KW_INT   = 24'h69_6e_74;
	localparam logic [31:0] KW_CHAR  = 32'h63_68_61_72;
	localparam logic [31:0] KW_FUNC  = 32'h66_75_6e_63;
	localparam logic [15:0] KW_IF    = 16'h69_66;
	localparam logic [39:0] KW_WHILE = 40'h77_68_69_6c_65;

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0d;
	localparam logic [7:0] CH_LF    = 8'h0a;
	localparam logic [7:0] CH_HASH  = 8'h23;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       final_byte;
	} scan_in_t;

	typedef struct packed {
		logic [KIND_W-1:0]  token_kind;
		logic [FIELD_W-1:0] token_start;
		logic [FIELD_W-1:0] token_length;
		logic [FIELD_W-1:0] token_line;
		logic               last_result;
	} scan_out_t;

	function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
		logic [KIND_W-1:0] k;
		begin
			case (c)
				8'h28: k = KIND_LPAREN;
				8'h29: k = KIND_RPAREN;
				8'h7b: k = KIND_LBRACE;
				8'h7d: k = KIND_RBRACE;
				8'h2b: k = KIND_PLUS;
				8'h2d: k = KIND_MINUS;
				8'h2a: k = KIND_STAR;
				8'h2f: k = KIND_SLASH;
				8'h3d: k = KIND_EQUAL;
				8'h3e: k = KIND_GT;
				8'h3c: k = KIND_LT;
				8'h2c: k = KIND_COMMA;
				8'h5e: k = KIND_CARET;
				default: k = KIND_END;
			endcase
			return k;
		end
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

endpackage
`default_nettype wire

/* design/script_token_scanner_top.sv */
// Script token scanner: one source byte per request in, tokens out.
// Latency: a token appears on tok_* the cycle after the byte that closes it is taken.
// Throughput: one byte per cycle while tok_ready is high and each byte yields at most one
// token; a byte that yields two or three tokens holds src_ready low until only its last
// token is left and being taken.
// Reset: arst_n clears the scanner to idle, position 0, line 1, and empties the buffer.
`default_nettype none
module script_token_scanner_top #(
	parameter int POS_BITS      = sts_pkg::POS_BITS_DEF,
	parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               src_valid,
	output logic              src_ready,
	input  wire sts_pkg::scan_in_t src_data,
	output logic              tok_valid,
	input  wire               tok_ready,
	output sts_pkg::scan_out_t tok_data
);

	localparam int WIN_W = KEYWORD_CHARS * 8;
	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

	sts_pkg::mode_t mode_q, mode_d;
	logic [POS_BITS-1:0] pos_q, pos_d;
	logic [POS_BITS-1:0] line_q, line_d;
	logic [POS_BITS-1:0] pstart_q, pstart_d;
	logic [POS_BITS-1:0] plen_q, plen_d;
	logic [WIN_W-1:0]    win_q, win_d;

	sts_pkg::scan_out_t slot_q [3];
	sts_pkg::scan_out_t new_slot [3];
	logic [1:0] cnt_q, new_cnt;

	sts_pkg::scan_out_t tok_f, tok_m, tok_e;
	logic v_f, v_m, v_e;
	logic push, pop;
	logic [7:0] c;
	logic fin;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == POS_MAX) ? v : v + POS_BITS'(1);
	endfunction

	function automatic logic [sts_pkg::KIND_W-1:0] name_kind(
		input logic [WIN_W-1:0] w,
		input logic [POS_BITS-1:0] len
	);
		logic [sts_pkg::KIND_W-1:0] k;
		begin
			k = sts_pkg::KIND_NAME;
			if (len == POS_BITS'(3) && w == WIN_W'(sts_pkg::KW_INT))
				k = sts_pkg::KIND_INT;
			else if (len == POS_BITS'(4) && w == WIN_W'(sts_pkg::KW_CHAR))
				k = sts_pkg::KIND_CHAR;
			else if (len == POS_BITS'(4) && w == WIN_W'(sts_pkg::KW_FUNC))
				k = sts_pkg::KIND_FUNC;
			else if (len == POS_BITS'(2) && w == WIN_W'(sts_pkg::KW_IF))
				k = sts_pkg::KIND_IF;
			else if (len == POS_BITS'(5) && w == WIN_W'(sts_pkg::KW_WHILE))
				k = sts_pkg::KIND_WHILE;
			return k;
		end
	endfunction

	assign c    = src_data.byte_value;
	assign fin  = src_data.final_byte;
	assign tok_valid = (cnt_q != 2'd0);
	assign tok_data  = slot_q[0];
	assign pop  = tok_valid && tok_ready;
	// buffer holds one byte's tokens; take the next byte once at most one is left and leaving
	assign src_ready = (cnt_q == 2'd0) || (cnt_q == 2'd1 && tok_ready);
	assign push = src_valid && src_ready;

	always_comb begin
		mode_d   = mode_q;
		line_d   = line_q;
		pstart_d = pstart_q;
		plen_d   = plen_q;
		win_d    = win_q;
		v_f = 1'b0;
		v_m = 1'b0;
		v_e = 1'b0;
		tok_f = '0;
		tok_m = '0;
		tok_e = '0;

		if ((mode_q == sts_pkg::MODE_NAME && (sts_pkg::is_letter(c) || sts_pkg::is_digit(c)))
			|| (mode_q == sts_pkg::MODE_NUMBER && sts_pkg::is_digit(c))) begin
			if (plen_q < POS_BITS'(KEYWORD_CHARS))
				win_d = {win_q[WIN_W-9:0], c};
			plen_d = sat_inc(plen_q);
		end else if (mode_q == sts_pkg::MODE_COMMENT) begin
			if (c == sts_pkg::CH_LF) begin
				line_d = sat_inc(line_q);
				mode_d = sts_pkg::MODE_IDLE;
			end
		end else begin
			// close the open name or number
			if (mode_q == sts_pkg::MODE_NAME || mode_q == sts_pkg::MODE_NUMBER) begin
				v_f = 1'b1;
				tok_f.token_kind   = (mode_q == sts_pkg::MODE_NAME) ?
					name_kind(win_q, plen_q) : sts_pkg::KIND_NUMBER;
				tok_f.token_start  = sts_pkg::FIELD_W'(pstart_q);
				tok_f.token_length = sts_pkg::FIELD_W'(plen_q);
				tok_f.token_line   = sts_pkg::FIELD_W'(line_q);
			end
			mode_d = sts_pkg::MODE_IDLE;
			if (c == sts_pkg::CH_SPACE || c == sts_pkg::CH_TAB || c == sts_pkg::CH_CR) begin
				mode_d = sts_pkg::MODE_IDLE;
			end else if (c == sts_pkg::CH_LF) begin
				line_d = sat_inc(line_q);
			end else if (c == sts_pkg::CH_HASH) begin
				mode_d = sts_pkg::MODE_COMMENT;
			end else if (sts_pkg::is_letter(c) || sts_pkg::is_digit(c)) begin
				mode_d   = sts_pkg::is_letter(c) ? sts_pkg::MODE_NAME : sts_pkg::MODE_NUMBER;
				pstart_d = pos_q;
				plen_d   = POS_BITS'(1);
				win_d    = WIN_W'(c);
			end else begin
				v_m = 1'b1;
				tok_m.token_kind   = sts_pkg::punct_kind(c);
				tok_m.token_start  = sts_pkg::FIELD_W'(pos_q);
				tok_m.token_length = sts_pkg::FIELD_W'(1);
				tok_m.token_line   = sts_pkg::FIELD_W'(line_q);
			end
		end

		pos_d = sat_inc(pos_q);

		if (fin) begin
			// a punctuation token leaves the scanner idle, so this never collides with tok_m
			if (mode_d == sts_pkg::MODE_NAME || mode_d == sts_pkg::MODE_NUMBER) begin
				v_m = 1'b1;
				tok_m.token_kind   = (mode_d == sts_pkg::MODE_NAME) ?
					name_kind(win_d, plen_d) : sts_pkg::KIND_NUMBER;
				tok_m.token_start  = sts_pkg::FIELD_W'(pstart_d);
				tok_m.token_length = sts_pkg::FIELD_W'(plen_d);
				tok_m.token_line   = sts_pkg::FIELD_W'(line_d);
			end
			v_e = 1'b1;
			tok_e.token_kind   = sts_pkg::KIND_END;
			tok_e.token_start  = sts_pkg::FIELD_W'(pos_d);
			tok_e.token_length = '0;
			tok_e.token_line   = sts_pkg::FIELD_W'(line_d);
			mode_d   = sts_pkg::MODE_IDLE;
			pos_d    = '0;
			line_d   = POS_BITS'(1);
			pstart_d = '0;
			plen_d   = '0;
			win_d    = '0;
		end

		tok_e.last_result = 1'b1;
		tok_m.last_result = !v_e;
		tok_f.last_result = !v_m && !v_e;

		// pack the valid tokens to the front, in order
		new_slot[0] = v_f ? tok_f : (v_m ? tok_m : tok_e);
		new_slot[1] = (v_f && v_m) ? tok_m : tok_e;
		new_slot[2] = tok_e;
		new_cnt = 2'(v_f) + 2'(v_m) + 2'(v_e);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= sts_pkg::MODE_IDLE;
			pos_q    <= '0;
			line_q   <= POS_BITS'(1);
			pstart_q <= '0;
			plen_q   <= '0;
			win_q    <= '0;
		end else if (push) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			line_q   <= line_d;
			pstart_q <= pstart_d;
			plen_q   <= plen_d;
			win_q    <= win_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (push) begin
			cnt_q <= new_cnt;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[0] <= new_slot[0];
			slot_q[1] <= new_slot[1];
			slot_q[2] <= new_slot[2];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

`ifndef SYNTHESIS
	a_last_slot_marked: assert property (@(posedge clk) disable iff (!arst_n)
		tok_valid && cnt_q == 2'd1 |-> tok_data.last_result)
		else $error("final buffered token lacks last_result");

	a_final_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		push && src_data.final_byte |=> mode_q == sts_pkg::MODE_IDLE && pos_q == '0
			&& line_q == POS_BITS'(1))
		else $error("scanner not back at start after final byte");

	a_final_gives_token: assert property (@(posedge clk) disable iff (!arst_n)
		push && src_data.final_byte |=> tok_valid)
		else $error("final byte produced no end token");

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0)
		else $error("line counter reached zero");
`endif

endmodule
`default_nettype wire

/* sim/token_stream_checker.sv */
// Token stream checker: predicts the tokens of each accepted source byte and compares them.
module token_stream_checker #(
	parameter int POS_BITS      = sts_pkg::POS_BITS_DEF,
	parameter int KEYWORD_CHARS = sts_pkg::KEYWORD_CHARS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               src_valid,
	input  logic               src_ready,
	input  sts_pkg::scan_in_t  src_data,
	input  logic               tok_valid,
	input  logic               tok_ready,
	input  sts_pkg::scan_out_t tok_data,
	output int                 fail_count,
	output int                 tokens_owed
);
	timeunit 1ns;
	timeprecision 1ps;
	import sts_pkg::*;

	localparam int WIN_W      = 8 * KEYWORD_CHARS;

	mode_t               scan_state;
	logic [POS_BITS-1:0] src_pos;
	logic [POS_BITS-1:0] line_no;
	logic [POS_BITS-1:0] tok_begin;
	logic [POS_BITS-1:0] tok_len;
	logic [WIN_W-1:0]    kw_window;

	scan_out_t expected_tokens[$];
	scan_out_t step_tokens[3];
	int        step_count;

	function automatic logic [POS_BITS-1:0] bump(input logic [POS_BITS-1:0] v);
		return (&v) ? v : v + 1'b1;
	endfunction

	function automatic logic alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic numeral(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic [KIND_W-1:0] symbol_kind(input logic [7:0] c);
		case (c)
			"(": return KIND_LPAREN;
			")": return KIND_RPAREN;
			"{": return KIND_LBRACE;
			"}": return KIND_RBRACE;
			"+": return KIND_PLUS;
			"-": return KIND_MINUS;
			"*": return KIND_STAR;
			"/": return KIND_SLASH;
			"=": return KIND_EQUAL;
			">": return KIND_GT;
			"<": return KIND_LT;
			",": return KIND_COMMA;
			"^": return KIND_CARET;
			default: return KIND_END;
		endcase
	endfunction

	// the window stops shifting once full, so the length check tells long names apart
	function automatic logic [KIND_W-1:0] word_kind();
		if (tok_len == 3 && kw_window == WIN_W'(KW_INT))
			return KIND_INT;
		if (tok_len == 4 && kw_window == WIN_W'(KW_CHAR))
			return KIND_CHAR;
		if (tok_len == 4 && kw_window == WIN_W'(KW_FUNC))
			return KIND_FUNC;
		if (tok_len == 2 && kw_window == WIN_W'(KW_IF))
			return KIND_IF;
		if (tok_len == 5 && kw_window == WIN_W'(KW_WHILE))
			return KIND_WHILE;
		return KIND_NAME;
	endfunction

	function automatic void add_token(input logic [KIND_W-1:0] kind,
			input logic [POS_BITS-1:0] start, input logic [POS_BITS-1:0] len,
			input logic [POS_BITS-1:0] line);
		scan_out_t t;
		t.token_kind   = kind;
		t.token_start  = FIELD_W'(start);
		t.token_length = FIELD_W'(len);
		t.token_line   = FIELD_W'(line);
		t.last_result  = 1'b0;
		step_tokens[step_count] = t;
		step_count++;
	endfunction

	function automatic void close_token();
		if (scan_state == MODE_NAME)
			add_token(word_kind(), tok_begin, tok_len, line_no);
		else if (scan_state == MODE_NUMBER)
			add_token(KIND_NUMBER, tok_begin, tok_len, line_no);
		scan_state = MODE_IDLE;
	endfunction

	function automatic void start_token(input mode_t m, input logic [7:0] c);
		scan_state = m;
		tok_begin  = src_pos;
		tok_len    = 1;
		kw_window  = WIN_W'(c);
	endfunction

	function automatic void grow_token(input logic [7:0] c);
		if (tok_len < KEYWORD_CHARS)
			kw_window = {kw_window[WIN_W-9:0], c};
		tok_len = bump(tok_len);
	endfunction

	function automatic void clear_scanner();
		scan_state = MODE_IDLE;
		src_pos    = '0;
		line_no    = 1;
		tok_begin  = '0;
		tok_len    = '0;
		kw_window  = '0;
	endfunction

	function automatic void predict_tokens(input scan_in_t req);
		logic [7:0] c;
		c = req.byte_value;
		step_count = 0;
		if (scan_state == MODE_NAME && (alpha(c) || numeral(c))) begin
			grow_token(c);
		end else if (scan_state == MODE_NUMBER && numeral(c)) begin
			grow_token(c);
		end else if (scan_state == MODE_COMMENT) begin
			if (c == CH_LF) begin
				line_no    = bump(line_no);
				scan_state = MODE_IDLE;
			end
		end else begin
			// pending name or number goes out on the old line, before any LF counts
			close_token();
			if (c == CH_SPACE || c == CH_TAB || c == CH_CR) begin
			end else if (c == CH_LF) begin
				line_no = bump(line_no);
			end else if (c == CH_HASH) begin
				scan_state = MODE_COMMENT;
			end else if (alpha(c)) begin
				start_token(MODE_NAME, c);
			end else if (numeral(c)) begin
				start_token(MODE_NUMBER, c);
			end else begin
				add_token(symbol_kind(c), src_pos, 1, line_no);
			end
		end
		src_pos = bump(src_pos);
		if (req.final_byte) begin
			close_token();
			add_token(KIND_END, src_pos, 0, line_no);
			clear_scanner();
		end
		if (step_count > 0)
			step_tokens[step_count-1].last_result = 1'b1;
		for (int i = 0; i < step_count; i++)
			expected_tokens.push_back(step_tokens[i]);
	endfunction

	function automatic void log_failure(input string msg);
		fail_count++;
		$display("%s", msg);
	endfunction

	function automatic void compare_field(input string what, input logic [FIELD_W-1:0] want,
			input logic [FIELD_W-1:0] got);
		if (got !== want)
			log_failure($sformatf("%0t: %s expected %0d, got %0d", $time, what, want, got));
	endfunction

	function automatic void check_token(input scan_out_t got);
		scan_out_t want;
		if (expected_tokens.size() == 0) begin
			log_failure($sformatf("%0t: expected no token, got kind %0d start %0d len %0d",
				$time, got.token_kind, got.token_start, got.token_length));
			return;
		end
		want = expected_tokens.pop_front();
		compare_field("token_kind", FIELD_W'(want.token_kind), FIELD_W'(got.token_kind));
		compare_field("token_start", want.token_start, got.token_start);
		compare_field("token_length", want.token_length, got.token_length);
		compare_field("token_line", want.token_line, got.token_line);
		compare_field("last_result", FIELD_W'(want.last_result), FIELD_W'(got.last_result));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_scanner();
			expected_tokens.delete();
			fail_count = 0;
		end else begin
			// predict first so a same-cycle token for this request would still find its entry
			if (src_valid && src_ready)
				predict_tokens(src_data);
			if (tok_valid && tok_ready)
				check_token(tok_data);
		end
		tokens_owed = expected_tokens.size();
	end

endmodule

/* sim/script_token_scanner_top_tb.sv */
// Testbench top for the script token scanner: source stimulus, token sink and verdict.
module script_token_scanner_top_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sts_pkg::*;

	localparam int POS_BITS        = POS_BITS_DEF;
	localparam int KEYWORD_CHARS   = KEYWORD_CHARS_DEF;
	localparam int ITEMS_PER_PHASE = 100;
	localparam int HOLD_CYCLES     = 200;
	localparam int STALL_LIMIT     = 2000;
	localparam int SETTLE_CYCLES   = 20;

	logic      clk;
	logic      arst_n;
	logic      src_valid;
	logic      src_ready;
	scan_in_t  src_data;
	logic      tok_valid;
	logic      tok_ready;
	scan_out_t tok_data;

	int fail_count;
	int tokens_owed;
	int src_idle_pct;
	int sink_stall_pct;
	int hold_requests;
	int bytes_sent;
	int quiet_cycles = 0;

	logic [7:0] src_text[$];

	script_token_scanner_top #(
		.POS_BITS      (POS_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_data  (src_data),
		.tok_valid (tok_valid),
		.tok_ready (tok_ready),
		.tok_data  (tok_data)
	);

	token_stream_checker #(
		.POS_BITS      (POS_BITS),
		.KEYWORD_CHARS (KEYWORD_CHARS)
	) i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.src_valid   (src_valid),
		.src_ready   (src_ready),
		.src_data    (src_data),
		.tok_valid   (tok_valid),
		.tok_ready   (tok_ready),
		.tok_data    (tok_data),
		.fail_count  (fail_count),
		.tokens_owed (tokens_owed)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// token sink: random stalls, plus a long hold-off whenever one is requested
	initial begin
		int holds_done;
		int hold_left;
		holds_done = 0;
		hold_left  = 0;
		tok_ready  = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				hold_left--;
				tok_ready <= 1'b0;
			end else if (holds_done != hold_requests) begin
				holds_done++;
				hold_left = HOLD_CYCLES;
				tok_ready <= 1'b0;
			end else begin
				tok_ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (src_valid && src_ready) || (tok_valid && tok_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// called at a rising edge; returns at the edge where the request is taken
	task automatic send_byte(input logic [7:0] b, input logic fin);
		logic rdy;
		while ($urandom_range(99) < src_idle_pct) begin
			src_valid <= 1'b0;
			@(posedge clk);
		end
		src_valid <= 1'b1;
		src_data.byte_value <= b;
		src_data.final_byte <= fin;
		do begin
			@(negedge clk);
			rdy = src_ready;
			@(posedge clk);
		end while (!rdy);
		bytes_sent++;
	endtask

	task automatic send_source();
		for (int i = 0; i < src_text.size(); i++)
			send_byte(src_text[i], i == src_text.size() - 1);
		src_text.delete();
	endtask

	function automatic void append_text(input string s);
		for (int i = 0; i < s.len(); i++)
			src_text.push_back(s[i]);
	endfunction

	function automatic logic [7:0] any_letter();
		return $urandom_range(1) ? 8'($urandom_range(97, 122)) : 8'($urandom_range(65, 90));
	endfunction

	function automatic logic [7:0] any_digit();
		return 8'($urandom_range(48, 57));
	endfunction

	function automatic string keyword_text(input int k);
		case (k)
			0: return "int";
			1: return "char";
			2: return "func";
			3: return "if";
			default: return "while";
		endcase
	endfunction

	function automatic string near_keyword_text(input int k);
		case (k)
			0: return "in";
			1: return "inte";
			2: return "chars";
			3: return "fun";
			4: return "iff";
			5: return "whil";
			6: return "whilee";
			7: return "Int";
			8: return "IF";
			default: return "int0";
		endcase
	endfunction

	function automatic logic [7:0] odd_char();
		string odd;
		odd = "!$%&.:;?@[]_|~'\"\\";
		case ($urandom_range(2))
			0: return 8'($urandom_range(128, 255));
			1: return 8'($urandom_range(0, 8));
			default: return odd[$urandom_range(odd.len() - 1)];
		endcase
	endfunction

	// mostly token-shaped text with random content, some raw noise
	function automatic void compose_source();
		int    pieces;
		int    pick;
		int    len;
		string punct;
		string blanks;
		punct  = "(){}+-*/=><,^";
		blanks = " \t\r";
		if ($urandom_range(99) < 15) begin
			repeat ($urandom_range(1, 10))
				src_text.push_back(8'($urandom_range(0, 255)));
			return;
		end
		pieces = $urandom_range(1, 10);
		for (int p = 0; p < pieces; p++) begin
			pick = $urandom_range(99);
			if (pick < 12) begin
				append_text(keyword_text($urandom_range(4)));
			end else if (pick < 20) begin
				append_text(near_keyword_text($urandom_range(9)));
			end else if (pick < 38) begin
				len = ($urandom_range(7) == 0) ? $urandom_range(6, 14) : $urandom_range(1, 6);
				src_text.push_back(any_letter());
				for (int i = 1; i < len; i++)
					src_text.push_back(($urandom_range(9) < 3) ? any_digit() : any_letter());
			end else if (pick < 50) begin
				repeat ($urandom_range(1, 5))
					src_text.push_back(any_digit());
			end else if (pick < 68) begin
				src_text.push_back(punct[$urandom_range(punct.len() - 1)]);
			end else if (pick < 76) begin
				src_text.push_back(blanks[$urandom_range(2)]);
			end else if (pick < 84) begin
				src_text.push_back(CH_LF);
			end else if (pick < 90) begin
				src_text.push_back(CH_HASH);
				repeat ($urandom_range(0, 6))
					src_text.push_back(8'($urandom_range(32, 126)));
				// a comment may stay open up to the final byte
				if (p != pieces - 1 || $urandom_range(1))
					src_text.push_back(CH_LF);
			end else if (pick < 95) begin
				src_text.push_back(odd_char());
			end else begin
				src_text.push_back(8'($urandom_range(0, 255)));
			end
			if (pick < 50 && $urandom_range(1))
				src_text.push_back(CH_SPACE);
		end
	endfunction

	initial begin
		int target;
		arst_n         = 1'b0;
		src_valid      = 1'b0;
		src_data       = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_requests  = 0;
		bytes_sent     = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every punctuation token, then the end token right after
		append_text("(){}+-*/=><,^");
		send_source();
		// byte extremes as unknown tokens, line count, long name, number closed by final
		src_text.push_back(8'h00);
		src_text.push_back(8'hff);
		append_text("\nwhilest\t0");
		send_source();
		// comment still open at the final byte
		append_text("#x");
		send_source();
		// a fresh source right after the final byte
		append_text("a");
		send_source();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					src_idle_pct = 0;
					sink_stall_pct <= 0;
				end
				1: begin
					src_idle_pct = 47;
					sink_stall_pct <= 0;
				end
				2: begin
					src_idle_pct = 0;
					sink_stall_pct <= 47;
				end
				default: begin
					src_idle_pct = 24;
					sink_stall_pct <= 24;
				end
			endcase
			if (ph == 0)
				hold_requests <= hold_requests + 1;
			target = bytes_sent + ITEMS_PER_PHASE;
			while (bytes_sent < target) begin
				compose_source();
				send_source();
			end
		end

		src_valid <= 1'b0;
		@(negedge clk);
		while (tokens_owed != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
		if (fail_count == 0 && tokens_owed == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
